// ===== rtl/wed_pkg.sv =====
`timescale 1ns / 1ps

package wed_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_FEATURE_BITS = 16;

  localparam int SUM_BITS       = 42;
  localparam int ROOT_BITS      = 21;
  localparam int RANGE_BITS     = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam int STEP_BITS      = $clog2(ROOT_BITS);

  localparam logic [RANGE_BITS-1:0] RANGE_BEGIN_RESET = RANGE_BITS'(0);
  localparam logic [RANGE_BITS-1:0] RANGE_END_RESET   = RANGE_BITS'(1024);

  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_BEGIN = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_END   = CFG_INDEX_BITS'(1);

  typedef struct packed {
    logic take;
    logic root_start;
    logic root_run;
  } wed_cmd_t;

  typedef struct packed {
    logic root_last;
  } wed_sts_t;

endpackage

// ===== rtl/windowed_euclidean_distance.sv =====
`timescale 1ns / 1ps

// channel   handshake              payload
// input     in_valid / in_stall    a_value, b_value, last
// output    out_valid / out_stall  distance_out
// config    cfg_write              cfg_index, cfg_data
//
// one element pair per cycle while a vector streams in
// the word with last is followed by an accumulate state (ST_LOAD), 21 square root
// steps (two radicand bits per step) in ST_ROOT and an output state (ST_OUT) that
// holds while out_stall is high
// input stalls from the last word until distance_out is taken
// rst is synchronous: window resets to [0, 1024), sum and index to zero

module windowed_euclidean_distance #(
  parameter int MAX_ELEMENTS = wed_pkg::DEF_MAX_ELEMENTS,
  parameter int FEATURE_BITS = wed_pkg::DEF_FEATURE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [wed_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wed_pkg::RANGE_BITS-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [FEATURE_BITS-1:0]     a_value,
  input  logic signed [FEATURE_BITS-1:0]     b_value,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [wed_pkg::ROOT_BITS-1:0]      distance_out
);
  import wed_pkg::*;

  wed_cmd_t cmd;
  wed_sts_t sts;

  wed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  wed_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .FEATURE_BITS (FEATURE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .a_value      (a_value),
    .b_value      (b_value),
    .last         (last),
    .distance_out (distance_out),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== rtl/wed_ctrl.sv =====
`timescale 1ns / 1ps

module wed_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_stall,
  output wed_pkg::wed_cmd_t cmd,
  input  wed_pkg::wed_sts_t sts
);
  import wed_pkg::*;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall       = (state != ST_RUN);
  assign out_valid      = (state == ST_OUT);
  assign cmd.take       = in_valid && (state == ST_RUN);
  assign cmd.root_start = (state == ST_LOAD);
  assign cmd.root_run   = (state == ST_ROOT);

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (cmd.take && last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (sts.root_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/wed_datapath.sv =====
`timescale 1ns / 1ps

module wed_datapath #(
  parameter int MAX_ELEMENTS = wed_pkg::DEF_MAX_ELEMENTS,
  parameter int FEATURE_BITS = wed_pkg::DEF_FEATURE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wed_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [wed_pkg::RANGE_BITS-1:0]       cfg_data,
  input  logic signed [FEATURE_BITS-1:0]       a_value,
  input  logic signed [FEATURE_BITS-1:0]       b_value,
  input  logic                                 last,
  output logic [wed_pkg::ROOT_BITS-1:0]        distance_out,
  input  wed_pkg::wed_cmd_t                    cmd,
  output wed_pkg::wed_sts_t                    sts
);
  import wed_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W = (IDX_W > RANGE_BITS) ? IDX_W : RANGE_BITS;
  localparam int MAG_W = FEATURE_BITS + 1;
  localparam int EXT_W = (MAG_W > ROOT_BITS) ? MAG_W : ROOT_BITS;
  localparam int REM_W = ROOT_BITS + 2;
  localparam int SH_W  = ROOT_BITS + 4;

  logic [RANGE_BITS-1:0] range_begin;
  logic [RANGE_BITS-1:0] range_end;
  logic [IDX_W-1:0]      element_index;

  // element stage
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [EXT_W-1:0]        mag_ext;
  logic                    mag_sat;
  logic [SUM_BITS-1:0]     square;
  logic [CMP_W-1:0]        idx_cmp;
  logic                    idx_live;
  logic                    in_window;

  logic                sq_valid;
  logic [SUM_BITS-1:0] sq_add;
  logic                sq_sat;

  // accumulate stage
  logic [SUM_BITS-1:0] square_sum;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_next;

  // square root
  logic [SUM_BITS-1:0]  radicand;
  logic [REM_W-1:0]     rem;
  logic [ROOT_BITS-1:0] root;
  logic [STEP_BITS-1:0] step;
  logic [SH_W-1:0]      rem_sh;
  logic [SH_W-1:0]      trial;
  logic                 trial_ok;

  assign diff    = MAG_W'(a_value) - MAG_W'(b_value);
  assign mag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign mag_ext = EXT_W'(mag);
  assign mag_sat = |(mag_ext >> ROOT_BITS);
  assign square  = SUM_BITS'(mag_ext[ROOT_BITS-1:0]) * SUM_BITS'(mag_ext[ROOT_BITS-1:0]);

  assign idx_cmp   = CMP_W'(element_index);
  assign idx_live  = (element_index < IDX_W'(MAX_ELEMENTS));
  assign in_window = idx_live && (idx_cmp >= CMP_W'(range_begin))
                     && (idx_cmp < CMP_W'(range_end));

  assign sum_wide = {1'b0, square_sum} + {1'b0, sq_add};
  assign sum_next = (sq_sat || sum_wide[SUM_BITS]) ? {SUM_BITS{1'b1}}
                                                    : sum_wide[SUM_BITS-1:0];

  assign rem_sh   = {rem, radicand[SUM_BITS-1 -: 2]};
  assign trial    = {2'b00, root, 2'b01};
  assign trial_ok = (rem_sh >= trial);

  assign sts.root_last = (step == STEP_BITS'(ROOT_BITS - 1));
  assign distance_out  = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_begin <= RANGE_BEGIN_RESET;
      range_end   <= RANGE_END_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RANGE_BEGIN: range_begin <= cfg_data;
        REG_RANGE_END:   range_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_index <= '0;
      sq_valid      <= 1'b0;
    end else begin
      sq_valid <= cmd.take;
      if (cmd.take) begin
        if (last) begin
          element_index <= '0;
        end else if (idx_live) begin
          element_index <= element_index + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sq_add <= in_window ? square : '0;
      sq_sat <= in_window && mag_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
    end else if (cmd.root_start) begin
      square_sum <= '0;
    end else if (sq_valid) begin
      square_sum <= sum_next;
    end
  end

  // two radicand bits per step, most significant first
  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      radicand <= sum_next;
      rem      <= '0;
      root     <= '0;
      step     <= '0;
    end else if (cmd.root_run) begin
      radicand <= radicand << 2;
      rem      <= trial_ok ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root     <= {root[ROOT_BITS-2:0], trial_ok};
      step     <= step + STEP_BITS'(1);
    end
  end

endmodule

// ===== tb/wed_checker.sv =====
`timescale 1ns / 1ps

module wed_checker #(
  parameter int MAX_ELEMENTS = wed_pkg::DEF_MAX_ELEMENTS,
  parameter int FEATURE_BITS = wed_pkg::DEF_FEATURE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [wed_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wed_pkg::RANGE_BITS-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [FEATURE_BITS-1:0]     a_value,
  input  logic signed [FEATURE_BITS-1:0]     b_value,
  input  logic                               last,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [wed_pkg::ROOT_BITS-1:0]      distance_out,
  output int                                 mismatches,
  output int                                 results_due
);
  import wed_pkg::*;

  localparam logic [SUM_BITS-1:0] SUM_FULL = '1;

  logic [SUM_BITS-1:0]   sum_sq;
  logic [RANGE_BITS-1:0] elem_idx;
  logic [RANGE_BITS-1:0] win_begin;
  logic [RANGE_BITS-1:0] win_end;
  logic [ROOT_BITS-1:0]  distance_q[$];

  function automatic logic [ROOT_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] x);
    logic [ROOT_BITS-1:0] r;
    logic [ROOT_BITS-1:0] t;
    r = '0;
    for (int i = ROOT_BITS - 1; i >= 0; i--) begin
      t = r | (ROOT_BITS'(1) << i);
      if (SUM_BITS'(t) * SUM_BITS'(t) <= x) r = t;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t distance_out %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic take_pair(input logic signed [FEATURE_BITS-1:0] a,
                           input logic signed [FEATURE_BITS-1:0] b, input logic l);
    logic signed [FEATURE_BITS:0] diff;
    logic [FEATURE_BITS:0]        mag;
    logic [SUM_BITS-1:0]          sq;
    diff = a - b;
    mag  = diff[FEATURE_BITS] ? -diff : diff;
    if (elem_idx < MAX_ELEMENTS && elem_idx >= win_begin && elem_idx < win_end) begin
      if ((mag >> ROOT_BITS) != 0) begin
        sum_sq = SUM_FULL;
      end else begin
        sq = SUM_BITS'(mag) * SUM_BITS'(mag);
        if (sq > SUM_FULL - sum_sq) sum_sq = SUM_FULL;
        else sum_sq = sum_sq + sq;
      end
    end
    if (elem_idx < MAX_ELEMENTS) elem_idx = elem_idx + 1'b1;
    if (l) begin
      distance_q.insert(distance_q.size(), floor_root(sum_sq));
      sum_sq   = '0;
      elem_idx = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sum_sq    = '0;
      elem_idx  = '0;
      win_begin = RANGE_BEGIN_RESET;
      win_end   = RANGE_END_RESET;
      distance_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (distance_q.size() == 0) begin
          report_mismatch("with no vector pending", distance_out, -1);
        end else begin
          if (distance_out !== distance_q[0])
            report_mismatch("wrong value", distance_out, distance_q[0]);
          void'(distance_q.pop_front());
        end
      end
      if (in_valid && !in_stall) take_pair(a_value, b_value, last);
      if (cfg_write) begin
        case (cfg_index)
          REG_RANGE_BEGIN: win_begin = cfg_data;
          REG_RANGE_END:   win_end   = cfg_data;
          default: ;
        endcase
      end
    end
    results_due <= distance_q.size();
  end

endmodule

// ===== tb/windowed_euclidean_distance_test.sv =====
`timescale 1ns / 1ps

module windowed_euclidean_distance_test;
  import wed_pkg::*;

  localparam int FEATURE_BITS = DEF_FEATURE_BITS;
  localparam int SHORT_ITEMS  = 1600;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic signed [FEATURE_BITS-1:0] FEAT_MAX = {1'b0, {(FEATURE_BITS-1){1'b1}}};
  localparam logic signed [FEATURE_BITS-1:0] FEAT_MIN = {1'b1, {(FEATURE_BITS-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = REG_RANGE_BEGIN;
  logic [RANGE_BITS-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [FEATURE_BITS-1:0] a_value = '0;
  logic signed [FEATURE_BITS-1:0] b_value = '0;
  logic                          last = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ROOT_BITS-1:0]          distance_out;

  int   mismatches;
  int   results_due;
  int   cycles = 0;
  int   burst_left = 0;
  int   words_sent = 0;
  logic hold_req = 1'b0;

  always #2 clk = ~clk;

  windowed_euclidean_distance u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .a_value      (a_value),
    .b_value      (b_value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .distance_out (distance_out)
  );

  wed_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .a_value      (a_value),
    .b_value      (b_value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .distance_out (distance_out),
    .mismatches   (mismatches),
    .results_due  (results_due)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    int pct;
    int span;
    pct  = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(32, 256);
          case ($urandom_range(3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
          endcase
        end
        span--;
        out_stall = ($urandom_range(99) < pct);
      end
    end
  end

  function automatic logic signed [FEATURE_BITS-1:0] pick_feature();
    case ($urandom_range(7))
      0: return FEAT_MAX;
      1: return FEAT_MIN;
      2: return '0;
      3, 4: return FEATURE_BITS'($urandom_range(1023) - 512);
      default: return FEATURE_BITS'($urandom());
    endcase
  endfunction

  task automatic put_word(input logic signed [FEATURE_BITS-1:0] a,
                          input logic signed [FEATURE_BITS-1:0] b, input logic l);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid = 1'b1;
    a_value  = a;
    b_value  = b;
    last     = l;
    do @(posedge clk); while (in_stall);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++) put_word(pick_feature(), pick_feature(), i == len - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input int first, input int stop);
    wait_drained();
    cfg_write = 1'b1;
    cfg_index = REG_RANGE_BEGIN;
    cfg_data  = RANGE_BITS'(first);
    @(negedge clk);
    cfg_index = REG_RANGE_END;
    cfg_data  = RANGE_BITS'(stop);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    int vec_count;
    int start_count;
    int first;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // extremes of the features under the reset window
    put_word(FEAT_MAX, FEAT_MIN, 1'b1);
    put_word(FEAT_MIN, FEAT_MAX, 1'b1);
    put_word(FEATURE_BITS'('h5555), FEATURE_BITS'('haaaa), 1'b0);
    put_word(FEATURE_BITS'('haaaa), FEATURE_BITS'('h5555), 1'b0);
    put_word('0, '0, 1'b1);
    put_word(FEAT_MIN, FEAT_MIN, 1'b1);

    set_window(2, 4);
    send_vector(6);
    // empty windows
    set_window(7, 7);
    send_vector(3);
    set_window(1024, 1024);
    send_vector(2);
    set_window(2047, 0);
    send_vector(2);

    // window moved in the middle of a vector
    set_window(0, 2047);
    put_word(pick_feature(), pick_feature(), 1'b0);
    put_word(pick_feature(), pick_feature(), 1'b0);
    set_window(1, 2047);
    put_word(pick_feature(), pick_feature(), 1'b0);
    put_word(pick_feature(), pick_feature(), 1'b1);

    // receiver holds off while vectors keep coming
    wait_drained();
    hold_req = 1'b1;
    send_vector(4);
    send_vector(4);
    send_vector(4);

    vec_count   = 0;
    start_count = words_sent;
    while (words_sent - start_count < SHORT_ITEMS) begin
      vec_count++;
      if (vec_count == 40) begin
        // index saturation past the element limit
        set_window(1000, 2047);
        send_vector($urandom_range(1025, 1100));
        continue;
      end
      if (vec_count == 15 || vec_count == 30) hold_req = 1'b1;
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(5))
          0: set_window(0, 1024);
          1: set_window(0, 2047);
          2: begin
            first = $urandom_range(8);
            set_window(first, $urandom_range(first, 16));
          end
          3: set_window($urandom_range(16), $urandom_range(16));
          4: begin
            if ($urandom_range(1)) set_window(1024, 1024);
            else set_window(2047, 2047);
          end
          default: set_window($urandom_range(2047), $urandom_range(2047));
        endcase
      end else if ($urandom_range(15) == 0) begin
        wait_drained();
      end
      if ($urandom_range(9) == 0) send_vector($urandom_range(17, 64));
      else send_vector($urandom_range(1, 16));
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
